// ===== hdl/rfcar_pkg.sv =====
// rfcar_pkg: constants, codes and field widths for the auto-ranging reciprocal
// frequency counter. No dependencies.
package rfcar_pkg;

    localparam int GATE_W   = 24;
    localparam int COUNT_W  = 15;
    localparam int ELAPSED_W = 32;
    localparam int FREQ_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int WIDE_W   = 64;

    localparam logic [COUNT_W-1:0] START_COUNT  = 15'd10;
    localparam logic [COUNT_W-1:0] THRESH_RESET = 15'd10000;
    localparam logic [GATE_W-1:0]  GATE_RESET   = 24'd100000;
    localparam logic [COUNT_W-1:0] MIN_RESET    = 15'd25;
    localparam logic [COUNT_W-1:0] MAX_RESET    = 15'd32500;

    localparam logic [31:0] US_PER_S    = 32'd1000000;
    localparam logic [31:0] KILO        = 32'd1000;
    localparam logic [31:0] FREQ_SPLIT  = 32'd100000;
    localparam logic [31:0] RANGE_SPLIT = 32'd32000;

    localparam logic [STATUS_W-1:0] ST_MEASURED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 2'd2;

endpackage

// ===== hdl/reciprocal_frequency_counter_autorange_top.sv =====
// Auto-ranging reciprocal frequency counter: one bit-serial shift-add
// multiplier and one restoring divider shared by a step sequencer.
// Depends on rfcar_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid / in_stall  | timed_out, elapsed_us
//  out     | output    | out_valid / out_stall| status, frequency_hz, next_count
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A measured transaction runs the serial multiplies and divisions in turn;
// four of the divisions are 64-step and three of the multiplies 32-step.
// A timeout or a zero elapsed time goes from accept straight to the output step.
// in_stall is high from accept until the result moves to the output register.
// The output register holds a result under out_stall while the next transaction
// waits in the output step.
// Reset sets the threshold to 10000 and the state, out_valid and limits to defaults.
module reciprocal_frequency_counter_autorange_top
    import rfcar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  timed_out,
    input  logic [ELAPSED_W-1:0]  elapsed_us,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [FREQ_W-1:0]     frequency_hz,
    output logic [COUNT_W-1:0]    next_count,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W      = 7;
    localparam int NUM_BITS   = 35;
    localparam int MUL_D_BITS = COUNT_W;
    localparam int MUL_T_BITS = 32;
    localparam int MUL_U_BITS = 20;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_STEP, S_OUT} state_t;
    typedef enum logic [3:0] {
        PH_NUM, PH_FREQ, PH_F1000, PH_TEL_MUL, PH_TEL_DIV, PH_TG_MUL, PH_TG_DIV,
        PH_U_MUL, PH_U_DIV, PH_TU_MUL, PH_TU_DIV
    } phase_t;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [WIDE_W-1:0]   acc_reg, acc_next;
    logic [WIDE_W-1:0]   mcand_reg, mcand_next;
    logic [31:0]         mplier_reg, mplier_next;
    logic [31:0]         div_reg, div_next;
    logic [31:0]         rem_reg, rem_next;
    logic [ELAPSED_W-1:0] el_reg, el_next;
    logic [FREQ_W-1:0]   freq_reg, freq_next;
    logic [31:0]         f1k_reg, f1k_next;
    logic                big_reg, big_next;
    logic                br_reg, br_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [COUNT_W-1:0]  thr_reg, thr_next;
    logic [GATE_W-1:0]   gate_reg, gate_next;
    logic [COUNT_W-1:0]  min_reg, min_next;
    logic [COUNT_W-1:0]  max_reg, max_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [FREQ_W-1:0]   out_freq_reg, out_freq_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign frequency_hz = out_freq_reg;
    assign next_count   = out_count_reg;

    always_comb
    begin
        logic [32:0]       rem_sh;
        logic [32:0]       diff;
        logic [WIDE_W-1:0] t_v;
        logic [WIDE_W-1:0] s_v;
        logic [FREQ_W-1:0] f_v;
        logic [31:0]       mp_v;
        logic [COUNT_W-1:0] d_v;

        state_next      = state_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        el_next         = el_reg;
        freq_next       = freq_reg;
        f1k_next        = f1k_reg;
        big_next        = big_reg;
        br_next         = br_reg;
        st_next         = st_reg;
        thr_next        = thr_reg;
        gate_next       = gate_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_freq_next   = out_freq_reg;
        out_count_next  = out_count_reg;

        rem_sh = {rem_reg, acc_reg[WIDE_W-1]};
        diff   = rem_sh - {1'b0, div_reg};
        t_v    = acc_reg + WIDE_W'(START_COUNT);
        s_v    = '0;
        f_v    = '0;
        mp_v   = big_reg ? f1k_reg : freq_reg;
        d_v    = (thr_reg > START_COUNT) ? (thr_reg - START_COUNT) : '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GATE_TIME: gate_next = cfg_data;
                CFG_MIN_COUNT: min_next  = cfg_data[COUNT_W-1:0];
                CFG_MAX_COUNT: max_next  = cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    el_next = elapsed_us;
                    if (timed_out)
                    begin
                        st_next    = ST_TIMEOUT;
                        freq_next  = '0;
                        thr_next   = min_reg;
                        state_next = S_OUT;
                    end
                    else if (elapsed_us == '0)
                    begin
                        st_next    = ST_ZERO;
                        freq_next  = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        st_next     = ST_MEASURED;
                        acc_next    = '0;
                        mcand_next  = WIDE_W'(US_PER_S);
                        mplier_next = 32'(d_v);
                        cnt_next    = CNT_W'(MUL_D_BITS);
                        phase_next  = PH_NUM;
                        state_next  = S_MUL;
                    end
                end
            end

            S_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[WIDE_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[31:1]};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_STEP;
                end
            end

            S_DIV:
            begin
                if (!diff[32])
                begin
                    rem_next = diff[31:0];
                    acc_next = {acc_reg[WIDE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                    acc_next = {acc_reg[WIDE_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_STEP;
                end
            end

            S_STEP:
            begin
                // remainder cleared so that a following division starts from zero
                rem_next = '0;
                unique case (phase_reg)
                    PH_NUM:
                    begin
                        acc_next   = {acc_reg[NUM_BITS-1:0], {(WIDE_W-NUM_BITS){1'b0}}};
                        div_next   = el_reg;
                        cnt_next   = CNT_W'(NUM_BITS);
                        phase_next = PH_FREQ;
                        state_next = S_DIV;
                    end
                    PH_FREQ:
                    begin
                        f_v = (|acc_reg[NUM_BITS-1:FREQ_W]) ? '1 : acc_reg[FREQ_W-1:0];
                        freq_next = f_v;
                        big_next  = (f_v > FREQ_SPLIT);
                        if (f_v == '0)
                        begin
                            thr_next   = min_reg;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            acc_next   = {f_v, 32'd0};
                            div_next   = KILO;
                            cnt_next   = CNT_W'(FREQ_W);
                            phase_next = PH_F1000;
                            state_next = S_DIV;
                        end
                    end
                    PH_F1000:
                    begin
                        f1k_next    = acc_reg[31:0];
                        acc_next    = '0;
                        mcand_next  = WIDE_W'(el_reg);
                        mplier_next = big_reg ? acc_reg[31:0] : freq_reg;
                        cnt_next    = CNT_W'(MUL_T_BITS);
                        phase_next  = PH_TEL_MUL;
                        state_next  = S_MUL;
                    end
                    PH_TEL_MUL, PH_TG_MUL, PH_TU_MUL:
                    begin
                        div_next   = big_reg ? KILO : US_PER_S;
                        cnt_next   = CNT_W'(WIDE_W);
                        phase_next = (phase_reg == PH_TEL_MUL) ? PH_TEL_DIV :
                                     (phase_reg == PH_TG_MUL)  ? PH_TG_DIV : PH_TU_DIV;
                        state_next = S_DIV;
                    end
                    PH_TEL_DIV:
                    begin
                        br_next     = (t_v > WIDE_W'(RANGE_SPLIT));
                        acc_next    = '0;
                        mcand_next  = WIDE_W'(gate_reg);
                        mplier_next = mp_v;
                        cnt_next    = CNT_W'(MUL_T_BITS);
                        phase_next  = PH_TG_MUL;
                        state_next  = S_MUL;
                    end
                    PH_TG_DIV:
                    begin
                        if (br_reg)
                        begin
                            if (t_v > WIDE_W'(max_reg))
                            begin
                                t_v = WIDE_W'(max_reg);
                            end
                        end
                        else
                        begin
                            if (t_v < WIDE_W'(min_reg))
                            begin
                                t_v = WIDE_W'(min_reg);
                            end
                        end
                        s_v = (t_v > WIDE_W'(START_COUNT)) ? (t_v - WIDE_W'(START_COUNT)) : '0;
                        acc_next    = '0;
                        mcand_next  = s_v;
                        mplier_next = US_PER_S;
                        cnt_next    = CNT_W'(MUL_U_BITS);
                        phase_next  = PH_U_MUL;
                        state_next  = S_MUL;
                    end
                    PH_U_MUL:
                    begin
                        div_next   = freq_reg;
                        cnt_next   = CNT_W'(WIDE_W);
                        phase_next = PH_U_DIV;
                        state_next = S_DIV;
                    end
                    PH_U_DIV:
                    begin
                        acc_next    = '0;
                        mcand_next  = acc_reg;
                        mplier_next = mp_v;
                        cnt_next    = CNT_W'(MUL_T_BITS);
                        phase_next  = PH_TU_MUL;
                        state_next  = S_MUL;
                    end
                    PH_TU_DIV:
                    begin
                        if (t_v > WIDE_W'(max_reg))
                        begin
                            thr_next = max_reg;
                        end
                        else if (t_v < WIDE_W'(min_reg))
                        begin
                            thr_next = min_reg;
                        end
                        else
                        begin
                            thr_next = t_v[COUNT_W-1:0];
                        end
                        state_next = S_OUT;
                    end
                    default: state_next = S_OUT;
                endcase
            end

            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_freq_next   = freq_reg;
                    out_count_next  = thr_reg;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_NUM;
            cnt_reg       <= '0;
            thr_reg       <= THRESH_RESET;
            gate_reg      <= GATE_RESET;
            min_reg       <= MIN_RESET;
            max_reg       <= MAX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            thr_reg       <= thr_next;
            gate_reg      <= gate_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        div_reg        <= div_next;
        rem_reg        <= rem_next;
        el_reg         <= el_next;
        freq_reg       <= freq_next;
        f1k_reg        <= f1k_next;
        big_reg        <= big_next;
        br_reg         <= br_next;
        st_reg         <= st_next;
        out_status_reg <= out_status_next;
        out_freq_reg   <= out_freq_next;
        out_count_reg  <= out_count_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input transaction accepted but sequencer not busy");

    a_freq_zero_unmeasured: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_TIMEOUT || status == ST_ZERO) |-> frequency_hz == '0)
        else $error("nonzero frequency on an unmeasured result");

    a_loop_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_DIV) |-> cnt_reg != '0)
        else $error("serial loop running with zero step count");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result loaded outside the output step");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for reciprocal_frequency_counter_autorange_top.
// Holds a scoreboard class that predicts each reading from the accepted gate
// transaction; plain tasks drive the block. Depends on rfcar_pkg and the RTL.
module testbench;
    import rfcar_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_AT     = 250;
    localparam int HOLD_CYCLES = 1500;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 92;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FREQ_W-1:0]   freq;
        logic [COUNT_W-1:0]  count;
    } reading_t;

    class gate_scoreboard;
        reading_t          expected_readings[$];
        logic [GATE_W-1:0]  gate_us;
        logic [COUNT_W-1:0] floor_count;
        logic [COUNT_W-1:0] ceil_count;
        logic [COUNT_W-1:0] threshold;
        int                 errors;

        function new();
            gate_us     = GATE_RESET;
            floor_count = MIN_RESET;
            ceil_count  = MAX_RESET;
            threshold   = THRESH_RESET;
            errors      = 0;
        endfunction

        function void set_limits(logic [GATE_W-1:0] g, logic [COUNT_W-1:0] lo,
                                 logic [COUNT_W-1:0] hi);
            gate_us     = g;
            floor_count = lo;
            ceil_count  = hi;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // pulses counted over usec microseconds, plus the start offset
        function logic [63:0] pulses_over(logic [63:0] usec, logic [63:0] f);
            if (f > FREQ_SPLIT)
                return f / KILO * usec / KILO + START_COUNT;
            return f * usec / US_PER_S + START_COUNT;
        endfunction

        function logic [63:0] above_start(logic [63:0] t);
            return (t > START_COUNT) ? t - START_COUNT : 64'd0;
        endfunction

        function logic [COUNT_W-1:0] retarget(logic [63:0] f, logic [63:0] usec);
            logic [63:0] t;
            logic [63:0] u;
            t = pulses_over(usec, f);
            if (t > RANGE_SPLIT) begin
                t = pulses_over(gate_us, f);
                if (t > ceil_count)
                    t = ceil_count;
            end
            else begin
                t = pulses_over(gate_us, f);
                if (t < floor_count)
                    t = floor_count;
            end
            u = above_start(t) * US_PER_S / f;
            t = pulses_over(u, f);
            if (t > ceil_count)
                t = ceil_count;
            else if (t < floor_count)
                t = floor_count;
            return t[COUNT_W-1:0];
        endfunction

        function void note_gate(logic to, logic [ELAPSED_W-1:0] el);
            reading_t    r;
            logic [63:0] f;
            f = 64'd0;
            if (to) begin
                r.status  = ST_TIMEOUT;
                threshold = floor_count;
            end
            else if (el == 0) begin
                r.status = ST_ZERO;
            end
            else begin
                r.status = ST_MEASURED;
                f = above_start(threshold) * US_PER_S / el;
                if (f > 64'hFFFF_FFFF)
                    f = 64'hFFFF_FFFF;
                if (f == 0)
                    threshold = floor_count;
                else
                    threshold = retarget(f, el);
            end
            r.freq  = f[FREQ_W-1:0];
            r.count = threshold;
            expected_readings.push_back(r);
        endfunction

        function void compare(string field, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, exp_v, act_v);
            end
        endfunction

        function void check_reading(logic [STATUS_W-1:0] st, logic [FREQ_W-1:0] fr,
                                    logic [COUNT_W-1:0] nc);
            reading_t r;
            if (expected_readings.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual %0d/%0d/%0d",
                         $time, st, fr, nc);
            end
            else begin
                r = expected_readings.pop_front();
                compare("status", r.status, st);
                compare("frequency_hz", r.freq, fr);
                compare("next_count", r.count, nc);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  timed_out;
    logic [ELAPSED_W-1:0]  elapsed_us;
    logic                  out_valid;
    logic                  out_stall;
    logic [STATUS_W-1:0]   status;
    logic [FREQ_W-1:0]     frequency_hz;
    logic [COUNT_W-1:0]    next_count;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gate_scoreboard sb;
    bit             steady;
    int             quiet_cycles;

    logic [GATE_W-1:0]  gate_set  [5] = '{24'd1, 24'd10000000, 24'd10000000, 24'd1000,
                                          24'd200000};
    logic [COUNT_W-1:0] floor_set [5] = '{15'd11, 15'd11, 15'd32767, 15'd11, 15'd20000};
    logic [COUNT_W-1:0] ceil_set  [5] = '{15'd32767, 15'd32767, 15'd32767, 15'd11,
                                          15'd100};

    reciprocal_frequency_counter_autorange_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .timed_out    (timed_out),
        .elapsed_us   (elapsed_us),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .frequency_hz (frequency_hz),
        .next_count   (next_count),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // elapsed time that a signal of frequency f gives with the current threshold
    function automatic logic [ELAPSED_W-1:0] elapsed_for(logic [63:0] f);
        logic [63:0] e;
        e = (sb.threshold - START_COUNT) * US_PER_S / f;
        if (e == 0)
            e = 64'd1;
        if (e > 64'hFFFF_FFFF)
            e = 64'hFFFF_FFFF;
        return e[ELAPSED_W-1:0];
    endfunction

    task automatic send_gate(input logic to, input logic [ELAPSED_W-1:0] el);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        timed_out  <= to;
        elapsed_us <= el;
        do @(posedge clk); while (in_stall);
        sb.note_gate(to, el);
    endtask

    task automatic write_limits(input logic [GATE_W-1:0] g, input logic [COUNT_W-1:0] lo,
                                input logic [COUNT_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GATE_TIME;
        cfg_data  <= g;
        @(posedge clk);
        cfg_index <= CFG_MIN_COUNT;
        cfg_data  <= CFG_DATA_W'(lo);
        @(posedge clk);
        cfg_index <= CFG_MAX_COUNT;
        cfg_data  <= CFG_DATA_W'(hi);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_limits(g, lo, hi);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_reading(status, frequency_hz, next_count);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("reciprocal_frequency_counter_autorange_top verification failed");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off to back the block up
    initial begin
        int n;
        int taken;
        taken = 0;
        out_stall <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (taken == HOLD_AT) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            n = steady ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial begin
        logic [63:0]        dir_freq [10];
        logic [63:0]        f;
        logic [GATE_W-1:0]  g;
        logic [COUNT_W-1:0] lo;
        logic [COUNT_W-1:0] hi;
        int                 pick;
        dir_freq = '{64'd1, 64'd100, 64'd99999, 64'd100000, 64'd100001, 64'd1000000,
                     64'd1000000, 64'd50000000, 64'd50000000, 64'd4000000000};
        sb           = new();
        steady       = 1'b0;
        quiet_cycles = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        timed_out  <= 1'b0;
        elapsed_us <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_GATE_TIME;
        cfg_data   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: saturation, timeout priority, zero elapsed, zero frequency
        send_gate(1'b0, 32'd1);
        send_gate(1'b1, 32'hFFFF_FFFF);
        send_gate(1'b0, 32'd0);
        send_gate(1'b1, 32'd0);
        send_gate(1'b0, 32'hFFFF_FFFF);
        foreach (dir_freq[i])
            send_gate(1'b0, elapsed_for(dir_freq[i]));

        for (int p = 0; p < PHASES; p++) begin
            if (p < 5) begin
                g  = gate_set[p];
                lo = floor_set[p];
                hi = ceil_set[p];
            end
            else begin
                g = GATE_W'($urandom_range(1, 9999));
                repeat ($urandom_range(0, 3)) g = GATE_W'(g * 10);
                lo = COUNT_W'($urandom_range(11, 400));
                hi = COUNT_W'($urandom_range(1000, 32767));
            end
            in_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clk);
            repeat (4) @(posedge clk);
            write_limits(g, lo, hi);
            steady = (p == 2 || p == 6);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    send_gate(1'b1, $urandom);
                else if (pick < 12)
                    send_gate(1'b0, 32'd0);
                else if (pick < 25)
                    send_gate(1'b0, $urandom);
                else begin
                    f = 64'($urandom_range(1, 999));
                    repeat ($urandom_range(0, 7)) f = f * 10;
                    send_gate(1'b0, elapsed_for(f));
                end
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (500) @(posedge clk);
        if (sb.errors == 0)
            $display("reciprocal_frequency_counter_autorange_top verification clean");
        else
            $display("reciprocal_frequency_counter_autorange_top verification failed");
        $finish;
    end

endmodule
